>>> rtl/core/iterative_path_smoother_defines.svh
// Assertion macros shared by the path smoother.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ITERATIVE_PATH_SMOOTHER_DEFINES_SVH
`define ITERATIVE_PATH_SMOOTHER_DEFINES_SVH

// Same-cycle implication.
`define IPS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("path smoother assertion failed");

// Next-cycle implication.
`define IPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("path smoother assertion failed");

`endif

>>> rtl/core/ips_pkg.sv
package ips_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = 40;
  localparam int DIFF_W     = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam logic [16:0] WEIGHT_RESET  = 17'd32768;
  localparam logic [31:0] TOL_RESET     = 32'd66;
  localparam logic [15:0] SWEEPS_RESET  = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS    = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last_out;
    logic               not_converged;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  // Stage strobes for the relaxation datapath.
  typedef struct packed {
    logic mul;
    logic sum;
    logic fin;
  } relax_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SW_START,
    ST_PRIME1,
    ST_PRIME2,
    ST_MUL,
    ST_SUM,
    ST_NEW,
    ST_DIF,
    ST_ACC,
    ST_SW_END,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

endpackage

>>> rtl/core/ips_ram.sv
module ips_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ips_relax.sv
module ips_relax (
  input  logic                clk,
  input  ips_pkg::relax_ctl_t ctl,
  input  logic [16:0]         a_wt,
  input  logic [16:0]         w_wt,
  input  logic signed [31:0]  s_val,
  input  logic signed [31:0]  o_val,
  input  logic signed [31:0]  p_val,
  input  logic signed [31:0]  n_val,
  output logic signed [31:0]  new_val
);

  logic signed [32:0] d_orig;
  logic signed [33:0] d_nbr;
  logic signed [50:0] pa_nxt, pa_r;
  logic signed [51:0] pb_nxt, pb_r;
  logic [52:0]        t_nxt, t_r;
  logic [36:0]        q;
  logic [37:0]        r;
  logic signed [31:0] new_nxt, new_r;

  assign d_orig = {o_val[31], o_val} - {s_val[31], s_val};
  assign d_nbr  = {{2{p_val[31]}}, p_val} + {{2{n_val[31]}}, n_val}
                - {s_val[31], s_val, 1'b0};
  assign pa_nxt = $signed({1'b0, a_wt}) * d_orig;
  assign pb_nxt = $signed({1'b0, w_wt}) * d_nbr;

  // Half an LSB of the result is added so that the floor below rounds ties up.
  assign t_nxt = {{2{pa_r[50]}}, pa_r} + {pb_r[51], pb_r} + 53'd32768;

  assign q = t_r[52:16];
  assign r = {{6{s_val[31]}}, s_val} + {q[36], q};

  always_comb begin
    if (!r[37] && (r[36:31] != 6'b000000)) begin
      new_nxt = 32'sh7FFFFFFF;
    end else if (r[37] && (r[36:31] != 6'b111111)) begin
      new_nxt = 32'sh80000000;
    end else begin
      new_nxt = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl.sum) begin
      t_r <= t_nxt;
    end
    if (ctl.fin) begin
      new_r <= new_nxt;
    end
  end

  assign new_val = new_r;

endmodule

>>> rtl/core/iterative_path_smoother.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   ips_pkg::in_item_t
// out_     output     out_valid/out_stall ips_pkg::out_item_t
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Points load at one per cycle until the item flagged last; the block then stalls its input.
// A sweep then reads, relaxes and writes back each interior point in turn around the
// smoothed-point memory, closing in ST_SW_END; with fewer than three points none is relaxed.
// Each result is then registered and held while the output stalls, after which loading resumes.
// Reset (synchronous, rst_n low) returns to loading with an empty path and default registers.
module iterative_path_smoother (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ips_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ips_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ips_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]      cfg_data
);

  `include "iterative_path_smoother_defines.svh"

  ips_pkg::state_t state_r, state_nxt;

  logic [16:0] weight_r;
  logic [31:0] tol_r;
  logic [15:0] sweeps_r;

  logic [ips_pkg::CNT_W-1:0] point_cnt_r, point_cnt_nxt;
  logic [ips_pkg::AW-1:0]    idx_r, idx_nxt;
  logic [15:0]               sweep_cnt_r, sweep_cnt_nxt;
  logic [ips_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                      nc_r, nc_nxt;
  logic                      ov_r, ov_nxt;

  ips_pkg::pt_t              prev_r, prev_nxt, cur_r, cur_nxt, next_r, next_nxt;
  logic [ips_pkg::DIFF_W-1:0] d_r, d_nxt;
  ips_pkg::out_item_t        od_r, od_nxt;

  logic                      sm_we, or_we;
  logic [ips_pkg::AW-1:0]    sm_waddr, sm_raddr, or_raddr;
  ips_pkg::pt_t              sm_wdata, or_wdata, sm_rdata, or_rdata;

  ips_pkg::relax_ctl_t       rctl;
  ips_pkg::pt_t              new_pt;
  logic [16:0]               w_eff, a_eff;
  logic [15:0]               cap;

  logic [32:0]               sum_old, sum_new;
  logic signed [33:0]        diff;
  logic [ips_pkg::SUM_W:0]   acc;
  logic [ips_pkg::CNT_W:0]   idx_ext, cnt_ext;

  assign w_eff = (weight_r > ips_pkg::ONE_Q16) ? ips_pkg::ONE_Q16 : weight_r;
  assign a_eff = ips_pkg::ONE_Q16 - w_eff;
  assign cap   = (sweeps_r == 16'd0) ? 16'd1 : sweeps_r;

  assign idx_ext = (ips_pkg::CNT_W+1)'(idx_r);
  assign cnt_ext = (ips_pkg::CNT_W+1)'(point_cnt_r);

  assign sum_old = {cur_r.x[31], cur_r.x} + {cur_r.y[31], cur_r.y};
  assign sum_new = {new_pt.x[31], new_pt.x} + {new_pt.y[31], new_pt.y};
  assign diff    = $signed({sum_old[32], sum_old}) - $signed({sum_new[32], sum_new});
  assign acc     = {1'b0, sum_r} + (ips_pkg::SUM_W+1)'(d_r);

  assign or_wdata = '{x: in_data.point_x, y: in_data.point_y};

  assign in_stall  = (state_r != ips_pkg::ST_LOAD);
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cfg_ready = 1'b1;

  ips_ram #(.WIDTH($bits(ips_pkg::pt_t)), .DEPTH(ips_pkg::MAX_POINTS)) u_orig_ram (
    .clk   (clk),
    .we    (or_we),
    .waddr (point_cnt_r[ips_pkg::AW-1:0]),
    .wdata (or_wdata),
    .raddr (or_raddr),
    .rdata (or_rdata)
  );

  ips_ram #(.WIDTH($bits(ips_pkg::pt_t)), .DEPTH(ips_pkg::MAX_POINTS)) u_smooth_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  ips_relax u_relax_x (
    .clk     (clk),
    .ctl     (rctl),
    .a_wt    (a_eff),
    .w_wt    (w_eff),
    .s_val   (cur_r.x),
    .o_val   (or_rdata.x),
    .p_val   (prev_r.x),
    .n_val   (sm_rdata.x),
    .new_val (new_pt.x)
  );

  ips_relax u_relax_y (
    .clk     (clk),
    .ctl     (rctl),
    .a_wt    (a_eff),
    .w_wt    (w_eff),
    .s_val   (cur_r.y),
    .o_val   (or_rdata.y),
    .p_val   (prev_r.y),
    .n_val   (sm_rdata.y),
    .new_val (new_pt.y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= ips_pkg::WEIGHT_RESET;
      tol_r    <= ips_pkg::TOL_RESET;
      sweeps_r <= ips_pkg::SWEEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ips_pkg::REG_SMOOTH_WEIGHT: weight_r <= cfg_data[16:0];
        ips_pkg::REG_TOLERANCE:     tol_r    <= cfg_data;
        ips_pkg::REG_MAX_SWEEPS:    sweeps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ips_pkg::ST_LOAD;
      point_cnt_r <= '0;
      idx_r       <= '0;
      sweep_cnt_r <= '0;
      sum_r       <= '0;
      nc_r        <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      point_cnt_r <= point_cnt_nxt;
      idx_r       <= idx_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sum_r       <= sum_nxt;
      nc_r        <= nc_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    next_r <= next_nxt;
    d_r    <= d_nxt;
    od_r   <= od_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    point_cnt_nxt = point_cnt_r;
    idx_nxt       = idx_r;
    sweep_cnt_nxt = sweep_cnt_r;
    sum_nxt       = sum_r;
    nc_nxt        = nc_r;
    ov_nxt        = ov_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    d_nxt         = d_r;
    od_nxt        = od_r;
    sm_we         = 1'b0;
    or_we         = 1'b0;
    sm_waddr      = point_cnt_r[ips_pkg::AW-1:0];
    sm_wdata      = or_wdata;
    sm_raddr      = '0;
    or_raddr      = idx_r;
    rctl          = '0;

    unique case (state_r)
      ips_pkg::ST_LOAD: begin
        if (in_valid) begin
          // Once the buffer is full further points are dropped, but last still starts a run.
          if (point_cnt_r < ips_pkg::CNT_W'(ips_pkg::MAX_POINTS)) begin
            sm_we         = 1'b1;
            or_we         = 1'b1;
            point_cnt_nxt = point_cnt_r + 1'b1;
          end
          if (in_data.last_in) begin
            sweep_cnt_nxt = '0;
            state_nxt     = ips_pkg::ST_SW_START;
          end
        end
      end
      ips_pkg::ST_SW_START: begin
        sum_nxt  = '0;
        sm_raddr = '0;
        if (point_cnt_r < ips_pkg::CNT_W'(3)) begin
          state_nxt = ips_pkg::ST_SW_END;
        end else begin
          state_nxt = ips_pkg::ST_PRIME1;
        end
      end
      ips_pkg::ST_PRIME1: begin
        prev_nxt  = sm_rdata;
        sm_raddr  = ips_pkg::AW'(1);
        state_nxt = ips_pkg::ST_PRIME2;
      end
      ips_pkg::ST_PRIME2: begin
        cur_nxt   = sm_rdata;
        idx_nxt   = ips_pkg::AW'(1);
        sm_raddr  = ips_pkg::AW'(2);
        or_raddr  = ips_pkg::AW'(1);
        state_nxt = ips_pkg::ST_MUL;
      end
      ips_pkg::ST_MUL: begin
        next_nxt  = sm_rdata;
        rctl.mul  = 1'b1;
        state_nxt = ips_pkg::ST_SUM;
      end
      ips_pkg::ST_SUM: begin
        rctl.sum  = 1'b1;
        state_nxt = ips_pkg::ST_NEW;
      end
      ips_pkg::ST_NEW: begin
        rctl.fin  = 1'b1;
        state_nxt = ips_pkg::ST_DIF;
      end
      ips_pkg::ST_DIF: begin
        sm_we     = 1'b1;
        sm_waddr  = idx_r;
        sm_wdata  = new_pt;
        d_nxt     = diff[33] ? ips_pkg::DIFF_W'(-diff) : ips_pkg::DIFF_W'(diff);
        state_nxt = ips_pkg::ST_ACC;
      end
      ips_pkg::ST_ACC: begin
        sum_nxt  = acc[ips_pkg::SUM_W] ? '1 : acc[ips_pkg::SUM_W-1:0];
        prev_nxt = new_pt;
        cur_nxt  = next_r;
        idx_nxt  = idx_r + 1'b1;
        // The following point is interior only if a neighbour lies beyond it.
        if (idx_ext + 3 <= cnt_ext) begin
          sm_raddr  = idx_r + ips_pkg::AW'(2);
          or_raddr  = idx_r + 1'b1;
          state_nxt = ips_pkg::ST_MUL;
        end else begin
          state_nxt = ips_pkg::ST_SW_END;
        end
      end
      ips_pkg::ST_SW_END: begin
        if (sum_r < ips_pkg::SUM_W'(tol_r)) begin
          nc_nxt    = 1'b0;
          idx_nxt   = '0;
          sm_raddr  = '0;
          state_nxt = ips_pkg::ST_EM_LD;
        end else if (17'(sweep_cnt_r) + 17'd1 >= 17'(cap)) begin
          nc_nxt    = 1'b1;
          idx_nxt   = '0;
          sm_raddr  = '0;
          state_nxt = ips_pkg::ST_EM_LD;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
          state_nxt     = ips_pkg::ST_SW_START;
        end
      end
      ips_pkg::ST_EM_LD: begin
        od_nxt.out_x         = sm_rdata.x;
        od_nxt.out_y         = sm_rdata.y;
        od_nxt.last_out      = (idx_ext + 1 == cnt_ext);
        od_nxt.not_converged = nc_r;
        ov_nxt               = 1'b1;
        state_nxt            = ips_pkg::ST_EM_WAIT;
      end
      ips_pkg::ST_EM_WAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (od_r.last_out) begin
            point_cnt_nxt = '0;
            state_nxt     = ips_pkg::ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            sm_raddr  = idx_r + 1'b1;
            state_nxt = ips_pkg::ST_EM_LD;
          end
        end
      end
      default: begin
        state_nxt = ips_pkg::ST_LOAD;
      end
    endcase
  end

  `IPS_ASSERT_IMPL(a_load_no_output, !in_stall, !out_valid)
  `IPS_ASSERT_NEXT(a_last_reloads, out_valid && !out_stall && out_data.last_out, !in_stall && point_cnt_r == '0)
  `IPS_ASSERT_IMPL(a_run_has_points, state_r == ips_pkg::ST_SW_START, point_cnt_r != '0)
  `IPS_ASSERT_IMPL(a_interior_index, state_r == ips_pkg::ST_DIF, idx_ext + 2 <= cnt_ext && idx_r != '0)

endmodule
